// ----- rtl/page_framebuffer_pixel_engine_unit_assert.svh -----
// Assertion macros for the paged framebuffer pixel engine checker.
// Depends on nothing; included by the checker file.
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is high.
`define PFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel engine check failed");

// Next-cycle implication, sampled on the rising clock edge, off while reset is high.
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel engine check failed");

`endif

// ----- rtl/pfe_pkg.sv -----
// Shared constants, types and codes of the paged framebuffer pixel engine.
// Depends on nothing; imported by every design module of the block.
package pfe_pkg;

   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 64;
   localparam int PAGE_ROWS   = 8;
   localparam int PAGES       = (MAX_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int STORE_DEPTH = MAX_WIDTH * PAGES;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int XW          = $clog2(MAX_WIDTH + 1);
   localparam int YW          = $clog2(PAGES * PAGE_ROWS + 1);
   localparam int PGW         = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int RST_W       = (128 > MAX_WIDTH) ? MAX_WIDTH : 128;
   localparam int RST_H       = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;

   localparam logic [2:0] OP_SET   = 3'd0;
   localparam logic [2:0] OP_CLR   = 3'd1;
   localparam logic [2:0] OP_INV   = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_TAKE  = 3'd5;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SET,
      ACT_CLR,
      ACT_INV,
      ACT_READ,
      ACT_TAKE
   } act_type;

   // Active display size after clamping.
   typedef struct packed {
      logic [XW-1:0] width;
      logic [YW-1:0] height;
   } dims_type;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      act_type        act;
      logic [AW-1:0]  addr;
      logic [7:0]     mask;
      logic [XW-1:0]  x;
      logic [PGW-1:0] page;
   } item_type;

   typedef struct packed {
      logic       in_range;
      logic [7:0] read_data;
      logic [7:0] dirty_left;
      logic [6:0] dirty_top;
      logic [7:0] dirty_right;
      logic [6:0] dirty_bottom;
      logic [3:0] first_page;
      logic [3:0] end_page;
   } rsp_type;

endpackage

// ----- rtl/page_framebuffer_pixel_engine_unit.sv -----
// Top level of the paged framebuffer pixel engine: configuration registers
// and the connection of pfe_front, pfe_back and pfe_rsp_queue. Depends on pfe_pkg.
//
//   channel   ports                       handshake
//   request   req_opcode .. byte_index    req_push / req_full
//   result    rsp_in_range .. end_page    rsp_pop / rsp_empty
//   config    csr_index, csr_wdata        csr_we, no wait
//
// Sustained rate is one request per cycle while the result queue has room; the
// store read-modify-write in the back end, with forwarding of the last write,
// sets that figure. After reset a clearing pass writes the 1024 store bytes,
// one per cycle, with req_full high; configuration writes are taken throughout.
// A full result queue stalls the back end, and the front queue then fills.
module page_framebuffer_pixel_engine_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_pixel_x,
   input  logic [7:0] req_pixel_y,
   input  logic       req_pixel_value,
   input  logic [9:0] req_byte_index,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_in_range,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_dirty_left,
   output logic [6:0] rsp_dirty_top,
   output logic [7:0] rsp_dirty_right,
   output logic [6:0] rsp_dirty_bottom,
   output logic [3:0] rsp_first_page,
   output logic [3:0] rsp_end_page,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import pfe_pkg::*;

   logic [7:0] width_ff, width_in;
   logic [6:0] height_ff, height_in;
   dims_type   dims;
   item_type   head_item;
   rsp_type    back_rsp, head_rsp;
   logic       head_valid, head_pop, busy, back_push, rsp_full;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata[6:0];
            default:    width_in  = width_ff;
         endcase
      end
      dims.width  = (32'(width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_ff);
      dims.height = (32'(height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 7'd64;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   pfe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_value (req_pixel_value),
      .req_byte_index  (req_byte_index),
      .dims            (dims),
      .busy            (busy),
      .head_pop        (head_pop),
      .head_valid      (head_valid),
      .head_item       (head_item)
   );

   pfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .busy       (busy),
      .rsp_push   (back_push),
      .rsp_data   (back_rsp),
      .rsp_full   (rsp_full)
   );

   pfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head_rsp)
   );

   assign rsp_in_range     = head_rsp.in_range;
   assign rsp_read_data    = head_rsp.read_data;
   assign rsp_dirty_left   = head_rsp.dirty_left;
   assign rsp_dirty_top    = head_rsp.dirty_top;
   assign rsp_dirty_right  = head_rsp.dirty_right;
   assign rsp_dirty_bottom = head_rsp.dirty_bottom;
   assign rsp_first_page   = head_rsp.first_page;
   assign rsp_end_page     = head_rsp.end_page;

endmodule

// ----- rtl/pfe_front.sv -----
// Front end: accepts requests, classifies them and computes store addresses,
// then holds them in a two-entry queue for the back end. Depends on pfe_pkg.
module pfe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_opcode,
   input  logic [7:0]        req_pixel_x,
   input  logic [7:0]        req_pixel_y,
   input  logic              req_pixel_value,
   input  logic [9:0]        req_byte_index,
   input  pfe_pkg::dims_type dims,
   input  logic              busy,
   input  logic              head_pop,
   output logic              head_valid,
   output pfe_pkg::item_type head_item
);
   import pfe_pkg::*;

   localparam int LW = PGW + XW + 1;

   item_type       item_in;
   item_type       ent_ff [2];
   logic [1:0]     cnt_ff, cnt_in;
   logic           wp_ff, wp_in;
   logic           rp_ff, rp_in;
   logic           accept;
   logic           hit;
   logic [PGW-1:0] page;
   logic [LW-1:0]  lin;

   always_comb begin
      hit  = (32'(req_pixel_x) < 32'(dims.width)) && (32'(req_pixel_y) < 32'(dims.height));
      page = PGW'(req_pixel_y >> 3);
      lin  = LW'(req_pixel_x) + LW'(page) * LW'(dims.width);

      item_in.addr = lin[AW-1:0];
      item_in.mask = 8'(1) << req_pixel_y[2:0];
      item_in.x    = XW'(req_pixel_x);
      item_in.page = page;
      item_in.act  = ACT_NONE;
      unique case (req_opcode)
         OP_SET:   item_in.act = hit ? ACT_SET : ACT_NONE;
         OP_CLR:   item_in.act = hit ? ACT_CLR : ACT_NONE;
         OP_INV:   item_in.act = hit ? ACT_INV : ACT_NONE;
         OP_WRITE: begin
            if (!hit)                 item_in.act = ACT_NONE;
            else if (req_pixel_value) item_in.act = ACT_SET;
            else                      item_in.act = ACT_CLR;
         end
         OP_READ: begin
            item_in.addr = AW'(req_byte_index);
            item_in.act  = (32'(req_byte_index) < STORE_DEPTH) ? ACT_READ : ACT_NONE;
         end
         OP_TAKE:  item_in.act = ACT_TAKE;
         default:  item_in.act = ACT_NONE;
      endcase
   end

   assign req_full   = (cnt_ff == 2'd2) || busy;
   assign accept     = req_push && !req_full;
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = ent_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, accept} - {1'b0, head_pop};
      wp_in  = accept ? !wp_ff : wp_ff;
      rp_in  = head_pop ? !rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff[wp_ff] <= item_in;
      end
   end

endmodule

// ----- rtl/pfe_back.sv -----
// Back end: owns the pixel store and the dirty rectangle, performs the
// read-modify-write with forwarding and builds results. Depends on pfe_pkg.
module pfe_back (
   input  logic              clock,
   input  logic              reset,
   input  pfe_pkg::dims_type dims,
   input  logic              head_valid,
   input  pfe_pkg::item_type head_item,
   output logic              head_pop,
   output logic              busy,
   output logic              rsp_push,
   output pfe_pkg::rsp_type  rsp_data,
   input  logic              rsp_full
);
   import pfe_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } bstate_type;

   bstate_type     state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           s2_valid_ff, s2_valid_in;
   item_type       s2_ff;
   logic [7:0]     mem [STORE_DEPTH];
   logic [7:0]     rd_ff;
   logic           last_valid_ff, last_valid_in;
   logic [AW-1:0]  last_addr_ff;
   logic [7:0]     last_data_ff;
   logic [XW-1:0]  min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic [YW-1:0]  min_y_ff, min_y_in, max_y_ff, max_y_in;

   logic           running, load, done, wr_en, is_pixel;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     old_byte, new_byte;
   logic [YW-1:0]  top_y, bot_y;
   logic [PGW:0]   page_next;
   logic [XW-1:0]  x_end;
   logic [YW:0]    bot_round;

   assign running  = (state_ff == ST_RUN);
   assign busy     = !running;
   assign done     = s2_valid_ff && !rsp_full;
   assign load     = running && head_valid && (!s2_valid_ff || !rsp_full);
   assign head_pop = load;
   assign rsp_push = done;
   // While the item in the second stage is stalled, its address is read again.
   assign rd_addr  = load ? head_item.addr : s2_ff.addr;

   always_comb begin
      // The write made on the same edge as this item's read is not in rd_ff yet.
      old_byte = (last_valid_ff && (last_addr_ff == s2_ff.addr)) ? last_data_ff : rd_ff;
      is_pixel = 1'b0;
      new_byte = old_byte;
      unique case (s2_ff.act)
         ACT_SET: begin
            is_pixel = 1'b1;
            new_byte = old_byte | s2_ff.mask;
         end
         ACT_CLR: begin
            is_pixel = 1'b1;
            new_byte = old_byte & ~s2_ff.mask;
         end
         ACT_INV: begin
            is_pixel = 1'b1;
            new_byte = old_byte ^ s2_ff.mask;
         end
         ACT_NONE, ACT_READ, ACT_TAKE: begin
            is_pixel = 1'b0;
         end
         default: begin
            is_pixel = 1'b0;
         end
      endcase
      wr_en = done && is_pixel;
   end

   always_comb begin
      top_y     = YW'({s2_ff.page, 3'b000});
      page_next = (PGW + 1)'(s2_ff.page) + (PGW + 1)'(1);
      bot_y     = YW'({page_next, 3'b000});
      x_end     = s2_ff.x + XW'(1);
      bot_round = (YW + 1)'(max_y_ff) + (YW + 1)'(PAGE_ROWS - 1);

      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      if (done && is_pixel) begin
         if (s2_ff.x < min_x_ff) min_x_in = s2_ff.x;
         if (x_end > max_x_ff)   max_x_in = x_end;
         if (top_y < min_y_ff)   min_y_in = top_y;
         if (bot_y > max_y_ff)   max_y_in = bot_y;
      end else if (done && (s2_ff.act == ACT_TAKE)) begin
         min_x_in = dims.width;
         max_x_in = '0;
         min_y_in = dims.height;
         max_y_in = '0;
      end

      rsp_data = '0;
      if (is_pixel) begin
         rsp_data.in_range = 1'b1;
      end else if (s2_ff.act == ACT_READ) begin
         rsp_data.read_data = old_byte;
      end else if (s2_ff.act == ACT_TAKE) begin
         rsp_data.dirty_left   = 8'(min_x_ff);
         rsp_data.dirty_top    = 7'(min_y_ff);
         rsp_data.dirty_right  = 8'(max_x_ff);
         rsp_data.dirty_bottom = 7'(max_y_ff);
         rsp_data.first_page   = 4'(min_y_ff >> 3);
         rsp_data.end_page     = 4'(bot_round >> 3);
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(STORE_DEPTH - 1)) state_in = ST_RUN;
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
      if (load)      s2_valid_in = 1'b1;
      else if (done) s2_valid_in = 1'b0;
      else           s2_valid_in = s2_valid_ff;
      last_valid_in = last_valid_ff || wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         s2_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
         min_x_ff      <= '0;
         min_y_ff      <= '0;
         max_x_ff      <= XW'(RST_W);
         max_y_ff      <= YW'(RST_H);
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         s2_valid_ff   <= s2_valid_in;
         last_valid_ff <= last_valid_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s2_ff <= head_item;
      end
      if (wr_en) begin
         last_addr_ff <= s2_ff.addr;
         last_data_ff <= new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         mem[clr_ff] <= 8'h00;
      end else if (wr_en) begin
         mem[s2_ff.addr] <= new_byte;
      end
      rd_ff <= mem[rd_addr];
   end

endmodule

// ----- rtl/pfe_rsp_queue.sv -----
// Two-entry result queue that separates the back end from the consumer.
// Depends on pfe_pkg for the result type.
module pfe_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfe_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output pfe_pkg::rsp_type head
);
   import pfe_pkg::*;

   rsp_type    ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic       take;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign take  = pop && !empty;
   assign head  = ent_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, take};
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = take ? !rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/pfe_checker.sv -----
// Port-level checks of the paged framebuffer pixel engine, bound to its top level.
// Depends on page_framebuffer_pixel_engine_unit_assert.svh.
`include "page_framebuffer_pixel_engine_unit_assert.svh"

module pfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_in_range,
   input logic [7:0] rsp_read_data,
   input logic [7:0] rsp_dirty_left,
   input logic [6:0] rsp_dirty_top,
   input logic [7:0] rsp_dirty_right,
   input logic [6:0] rsp_dirty_bottom,
   input logic [3:0] rsp_first_page,
   input logic [3:0] rsp_end_page
);

   logic       pixel_extras_zero;
   logic       rsp_waiting;
   logic [8:0] rsp_head_bits;

   assign pixel_extras_zero = (rsp_read_data == 8'd0) && (rsp_dirty_left == 8'd0) &&
                              (rsp_dirty_top == 7'd0) && (rsp_dirty_right == 8'd0) &&
                              (rsp_dirty_bottom == 7'd0) && (rsp_first_page == 4'd0) &&
                              (rsp_end_page == 4'd0);
   assign rsp_waiting       = !rsp_empty && !rsp_pop;
   assign rsp_head_bits     = {rsp_in_range, rsp_read_data};

   // Right after reset the store is being cleared and no result is waiting.
   `PFE_ASSERT_NOW(a_reset_state, clock, reset, $past(reset), req_full && !(!rsp_empty))

   // A pixel result carries nothing of the read or take results.
   `PFE_ASSERT_NOW(a_pixel_only, clock, reset, !rsp_empty && rsp_in_range, pixel_extras_zero)

   // The first page always agrees with the reported top row.
   `PFE_ASSERT_NOW(a_first_page, clock, reset, !rsp_empty, rsp_first_page == rsp_dirty_top[6:3])

   // A waiting result stays, with in-range flag and read data unchanged, until taken.
   `PFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, !rsp_empty && $stable(rsp_head_bits))

endmodule

bind page_framebuffer_pixel_engine_unit pfe_checker u_pfe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_in_range     (rsp_in_range),
   .rsp_read_data    (rsp_read_data),
   .rsp_dirty_left   (rsp_dirty_left),
   .rsp_dirty_top    (rsp_dirty_top),
   .rsp_dirty_right  (rsp_dirty_right),
   .rsp_dirty_bottom (rsp_dirty_bottom),
   .rsp_first_page   (rsp_first_page),
   .rsp_end_page     (rsp_end_page)
);
